[design/zrwd_pkg.sv]
// ----------------------------------------------------------------------------
// Zero-run word decompressor package
// Sizes, field types and the command and status bundles shared between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package zrwd_pkg;

  // Output words per block and used bits of one input word.
  localparam int BLOCK_WORDS = 64;
  localparam int WORD_BITS   = 16;

  // Tag words that open a block and the bits they hold.
  localparam int TAG_WORDS = (BLOCK_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int TAG_BITS  = TAG_WORDS * WORD_BITS;

  // Field width on the channels.
  localparam int FIELD_W = 16;

  // Position in a block (0 .. BLOCK_WORDS), bit index, tag word count.
  localparam int POS_W = $clog2(BLOCK_WORDS + 1);
  localparam int IDX_W = $clog2(BLOCK_WORDS);
  localparam int CNT_W = $clog2(TAG_WORDS + 1);

  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // take the input beat (tag word or data word)
    logic emit_zero;  // write a zero word into the output register
    logic skip;       // run found a set bit at once: close the item
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic tag_mode;      // still collecting tag words
    logic tag_complete;  // the next tag word completes the tag
    logic cur_set;       // tag bit at the current position is set
    logic stop;          // a word written now ends the run
    logic out_free;      // output register can take a beat this cycle
  } status_t;

endpackage

[design/zrwd_if.sv]
// ----------------------------------------------------------------------------
// Zero-run word decompressor channels
// Input channel carries compressed words, output channel decompressed words.
// ----------------------------------------------------------------------------
interface zrwd_in_if;
  import zrwd_pkg::*;

  logic   valid;
  logic   ready;
  field_t word;
  logic   last_in;

  modport source (output valid, output word, output last_in, input ready);
  modport sink   (input valid, input word, input last_in, output ready);
endinterface

interface zrwd_out_if;
  import zrwd_pkg::*;

  logic   valid;
  logic   ready;
  field_t value;
  logic   last_of_run;
  logic   end_of_block;

  modport source (output valid, output value, output last_of_run, output end_of_block,
                  input ready);
  modport sink   (input valid, input value, input last_of_run, input end_of_block,
                  output ready);
endinterface

[design/zrwd_datapath.sv]
// ----------------------------------------------------------------------------
// Zero-run word decompressor datapath
// Holds the tag, the tag word count, the block position and the output
// register, and updates them on commands from the controller.
// ----------------------------------------------------------------------------
module zrwd_datapath
  import zrwd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output status_t st_o,
  input  field_t  in_word_i,
  input  logic    in_last_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output field_t  out_value_o,
  output logic    out_last_of_run_o,
  output logic    out_end_of_block_o
);

  tag_t   tag_q, tag_d;
  cnt_t   cnt_q, cnt_d;
  pos_t   pos_q, pos_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  field_t out_value_q, out_value_d;
  logic   out_lor_q, out_lor_d;
  logic   out_eob_q, out_eob_d;

  word_t            w;
  pos_t             pos_inc;
  logic             at_end;
  logic             tag_mode;
  logic             stop;
  logic             out_load;
  logic             clear;

  always_comb begin
    w        = in_word_i[WORD_BITS-1:0];
    pos_inc  = pos_q + pos_t'(1);
    at_end   = (pos_q == pos_t'(BLOCK_WORDS - 1));
    tag_mode = (cnt_q != cnt_t'(TAG_WORDS));
    stop     = at_end || tag_q[pos_inc[IDX_W-1:0]];

    st_o.tag_mode     = tag_mode;
    st_o.tag_complete = (cnt_q == cnt_t'(TAG_WORDS - 1));
    st_o.cur_set      = tag_q[pos_q[IDX_W-1:0]];
    st_o.stop         = stop;
    st_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_comb begin
    tag_d       = tag_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    last_d      = last_q;
    out_value_d = out_value_q;
    out_lor_d   = out_lor_q;
    out_eob_d   = out_eob_q;
    out_load    = 1'b0;
    clear       = 1'b0;

    if (cmd_i.load) begin
      last_d = in_last_i;
      if (tag_mode) begin
        tag_d[cnt_q*WORD_BITS +: WORD_BITS] = w;
        cnt_d = cnt_q + cnt_t'(1);
        pos_d = '0;
        // A partial tag at the end of the stream is dropped.
        if (in_last_i && cnt_q != cnt_t'(TAG_WORDS - 1)) begin
          clear = 1'b1;
        end
      end else begin
        out_load    = 1'b1;
        out_value_d = field_t'(w);
        out_lor_d   = stop;
        out_eob_d   = at_end;
        pos_d       = pos_inc;
        clear       = stop && (at_end || in_last_i);
      end
    end else if (cmd_i.emit_zero) begin
      out_load    = 1'b1;
      out_value_d = '0;
      out_lor_d   = stop;
      out_eob_d   = at_end;
      pos_d       = pos_inc;
      clear       = stop && (at_end || last_q);
    end else if (cmd_i.skip) begin
      clear = last_q;
    end

    if (clear) begin
      tag_d = '0;
      cnt_d = '0;
      pos_d = '0;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tag_q       <= tag_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_lor_q   <= out_lor_d;
    out_eob_q   <= out_eob_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_value_o        = out_value_q;
  assign out_last_of_run_o  = out_lor_q;
  assign out_end_of_block_o = out_eob_q;

endmodule

[design/zrwd_ctrl.sv]
// ----------------------------------------------------------------------------
// Zero-run word decompressor controller
// Accepts input beats while idle and steps through runs of zero words.
// ----------------------------------------------------------------------------
module zrwd_ctrl
  import zrwd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    accept        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = st_i.out_free;
        accept     = in_valid_i && st_i.out_free;
        cmd_o.load = accept;
        if (accept) begin
          if (st_i.tag_mode ? st_i.tag_complete : !st_i.stop) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (st_i.cur_set) begin
          // Only right after a tag completes: the first word carries data.
          cmd_o.skip = 1'b1;
          state_d    = ST_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.emit_zero = 1'b1;
          if (st_i.stop) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/zero_run_word_decompressor.sv]
// ----------------------------------------------------------------------------
// Zero-run word decompressor
// Expands tagged blocks of 16-bit words into 64-word blocks with zero fill.
// ----------------------------------------------------------------------------
// Usage: compressed words arrive as beats on in_i (word, last_in). Each block
// opens with four tag words, least significant first; a set tag bit takes the
// next data beat, a clear bit yields a zero word. Decompressed words leave as
// beats on out_o (value, last_of_run, end_of_block) from an output register.
// A data beat is registered: it shows on out_o the cycle after it is taken.
// Throughput: tag words and data beats are accepted while idle. A data beat
// followed by zero words, or a completed tag, starts a run; a completed tag
// whose first bit is set ends its run at once. The controller walks a run
// of zeros one word per cycle through the output register while it is free,
// and no new beat is accepted until the run is finished.
// Reset: all control state clears; the next beat starts a tag. A beat with
// last_in set ends the stream: its words go out, then state returns to reset.
// Stalls: when out_o.ready is low the output register holds its beat, the run
// pauses and in_i.ready falls until the register can take a new beat.
// ----------------------------------------------------------------------------
module zero_run_word_decompressor
  import zrwd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  zrwd_in_if.sink    in_i,
  zrwd_out_if.source out_o
);

  cmd_t    cmd;
  status_t st;

  // The controller decides when to accept a beat and when to emit zeros.
  zrwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // The datapath owns the tag, the block position and the output register.
  zrwd_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .in_word_i          (in_i.word),
    .in_last_i          (in_i.last_in),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_value_o        (out_o.value),
    .out_last_of_run_o  (out_o.last_of_run),
    .out_end_of_block_o (out_o.end_of_block)
  );

  // An input beat is taken only when the output register is free for it.
  a_accept_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !out_o.valid || out_o.ready)
    else $error("input beat accepted while output register is blocked");

  // The last word of a block always closes the run of its item.
  a_eob_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.end_of_block |-> out_o.last_of_run)
    else $error("end of block without end of run");

  // Zero words are only produced once the tag is complete.
  a_zero_after_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_zero |-> !st.tag_mode)
    else $error("zero word emitted while tag incomplete");

  // A zero word is written into the output register only when it is free.
  a_zero_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_zero |-> !cmd.load && st.out_free)
    else $error("zero word emitted into a busy output register");

endmodule
